### rtl/lba_pkg.sv
// Shared types and constants of the linked bucket allocator.
// Used by lba_link_table, the allocator and its testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lba_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int SIZE_BITS   = 16;
    localparam int IDX_W       = $clog2(NUM_BUCKETS);
    localparam int ID_W        = $clog2(NUM_BUCKETS + 1);

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [SIZE_BITS-1:0] t_size;

    localparam t_id NONE_ID = ID_W'(NUM_BUCKETS);

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_INSPECT = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] alloc_size;
        logic [5:0]  bkt_sel;
        logic [6:0]  prev_id;
        logic        end_of_batch;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [6:0]  granted_id;
        logic [6:0]  link_out;
        logic [15:0] size_out;
        logic [6:0]  first_out;
        logic [6:0]  last_out;
        logic [6:0]  free_head_out;
        logic [6:0]  in_use_out;
    } t_out_word;

    typedef struct packed {
        logic rd;
        logic wr;
        t_idx addr;
        t_id  wdata;
    } t_link_req;

endpackage

`default_nettype wire

### rtl/lba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/lba_link_table.sv
// Next-link table: RAM plus per-entry written flags; an unwritten entry reads as index+1.
// Depends on lba_pkg and lba_ram.
`timescale 1ns / 1ps
`default_nettype none

module lba_link_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lba_pkg::t_link_req i_req,
    output lba_pkg::t_id            o_rdata
);

    logic [lba_pkg::NUM_BUCKETS-1:0] r_init;
    lba_pkg::t_idx                   r_rd_addr;
    logic                            r_rd_init;
    lba_pkg::t_id                    ram_q;

    lba_ram #(
        .WIDTH(lba_pkg::ID_W),
        .DEPTH(lba_pkg::NUM_BUCKETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.wr),
        .i_waddr(i_req.addr),
        .i_wdata(i_req.wdata),
        .i_re   (i_req.rd),
        .i_raddr(i_req.addr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_req.wr) begin
            r_init[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rd_addr <= i_req.addr;
            r_rd_init <= r_init[i_req.addr];
        end
    end

    assign o_rdata = r_rd_init ? ram_q
                               : lba_pkg::ID_W'(r_rd_addr) + lba_pkg::ID_W'(1);

endmodule

`default_nettype wire

### rtl/linked_bucket_allocator.sv
// Linked bucket allocator: free list and active list sharing one link table.
// Result word registered in S_DONE after the states of its mode, one link access per cycle;
// one word in flight, the next word is accepted the cycle after the result is registered,
// so the next word waits for the current result and any output stall.
// Reset (synchronous, active low) empties the active list and fills the free list; link entries carry written
// flags, so no clearing pass is needed. Depends on lba_pkg, lba_link_table, lba_ram.
`timescale 1ns / 1ps
`default_nettype none

module linked_bucket_allocator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire lba_pkg::t_in_word i_word,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output lba_pkg::t_out_word     o_word
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_C_RD    = 4'd1;
    localparam logic [3:0] S_C_W1    = 4'd2;
    localparam logic [3:0] S_C_W2    = 4'd3;
    localparam logic [3:0] S_A_RD    = 4'd4;
    localparam logic [3:0] S_A_W1    = 4'd5;
    localparam logic [3:0] S_A_W2    = 4'd6;
    localparam logic [3:0] S_R_CHK   = 4'd7;
    localparam logic [3:0] S_R_CMP   = 4'd8;
    localparam logic [3:0] S_R_START = 4'd9;
    localparam logic [3:0] S_I_RD    = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [3:0]         r_ret, n_ret;
    lba_pkg::t_in_word  r_word, n_word;
    lba_pkg::t_out_word r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic               r_status, n_status;
    lba_pkg::t_id       r_gid, n_gid;
    lba_pkg::t_id       r_tmp, n_tmp;
    lba_pkg::t_id       r_free_head, n_free_head;
    lba_pkg::t_id       r_first, n_first;
    lba_pkg::t_id       r_last, n_last;
    lba_pkg::t_id       r_in_use, n_in_use;
    logic               r_run_open, n_run_open;
    lba_pkg::t_id       r_run_start, n_run_start;
    lba_pkg::t_id       r_run_prev, n_run_prev;
    lba_pkg::t_id       r_run_end, n_run_end;
    lba_pkg::t_id       r_run_len, n_run_len;

    lba_pkg::t_link_req link_req;
    lba_pkg::t_id       link_rd;
    logic               size_we;
    logic               size_re;
    lba_pkg::t_idx      size_addr;
    lba_pkg::t_size     size_rd;

    logic               bid_ok;
    logic               pid_ok;
    lba_pkg::t_id       bid;
    logic [3:0]         op_state;

    lba_link_table u_link (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (link_req),
        .o_rdata(link_rd)
    );

    lba_ram #(
        .WIDTH(lba_pkg::SIZE_BITS),
        .DEPTH(lba_pkg::NUM_BUCKETS)
    ) u_size (
        .i_clk  (i_clk),
        .i_we   (size_we),
        .i_waddr(size_addr),
        .i_wdata(lba_pkg::SIZE_BITS'(r_word.alloc_size)),
        .i_re   (size_re),
        .i_raddr(size_addr),
        .o_rdata(size_rd)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    assign bid_ok = (32'(r_word.bkt_sel) < lba_pkg::NUM_BUCKETS);
    assign pid_ok = (32'(r_word.prev_id) < lba_pkg::NUM_BUCKETS);
    assign bid    = lba_pkg::ID_W'(r_word.bkt_sel);

    always_comb begin
        case (i_word.mode)
            lba_pkg::MODE_ALLOC:   op_state = S_A_RD;
            lba_pkg::MODE_RELEASE: op_state = S_R_CHK;
            lba_pkg::MODE_INSPECT: op_state = S_I_RD;
            default:               op_state = S_DONE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_word      = r_word;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_gid       = r_gid;
        n_tmp       = r_tmp;
        n_free_head = r_free_head;
        n_first     = r_first;
        n_last      = r_last;
        n_in_use    = r_in_use;
        n_run_open  = r_run_open;
        n_run_start = r_run_start;
        n_run_prev  = r_run_prev;
        n_run_end   = r_run_end;
        n_run_len   = r_run_len;
        link_req    = '0;
        size_we     = 1'b0;
        size_re     = 1'b0;
        size_addr   = lba_pkg::IDX_W'(r_word.bkt_sel);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_word   = i_word;
                    n_status = 1'b0;
                    n_gid    = lba_pkg::NONE_ID;
                    if (i_word.mode != lba_pkg::MODE_RELEASE && r_run_open) begin
                        n_state = S_C_RD;
                        n_ret   = op_state;
                    end else begin
                        n_state = op_state;
                    end
                end
            end
            S_C_RD: begin
                if (r_run_open) begin
                    link_req.rd   = 1'b1;
                    link_req.addr = lba_pkg::IDX_W'(r_run_end);
                    n_state       = S_C_W1;
                end else begin
                    n_state = r_ret;
                end
            end
            S_C_W1: begin
                if (r_run_prev < lba_pkg::NONE_ID) begin
                    link_req.wr    = 1'b1;
                    link_req.addr  = lba_pkg::IDX_W'(r_run_prev);
                    link_req.wdata = link_rd;
                    if (link_rd >= lba_pkg::NONE_ID) begin
                        n_last = r_run_prev;
                    end
                end else if (link_rd < lba_pkg::NONE_ID) begin
                    n_first = link_rd;
                end else begin
                    n_first = lba_pkg::NONE_ID;
                    n_last  = lba_pkg::NONE_ID;
                end
                n_state = S_C_W2;
            end
            S_C_W2: begin
                link_req.wr    = 1'b1;
                link_req.addr  = lba_pkg::IDX_W'(r_run_end);
                link_req.wdata = r_free_head;
                n_free_head    = r_run_start;
                n_in_use       = (r_in_use > r_run_len) ? r_in_use - r_run_len : '0;
                n_run_len      = '0;
                n_run_open     = 1'b0;
                n_state        = r_ret;
            end
            S_A_RD: begin
                if (r_free_head < lba_pkg::NONE_ID) begin
                    link_req.rd   = 1'b1;
                    link_req.addr = lba_pkg::IDX_W'(r_free_head);
                    n_state       = S_A_W1;
                end else begin
                    n_status = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_A_W1: begin
                n_tmp = link_rd;
                n_gid = r_free_head;
                if (r_last < lba_pkg::NONE_ID) begin
                    link_req.wr    = 1'b1;
                    link_req.addr  = lba_pkg::IDX_W'(r_last);
                    link_req.wdata = r_free_head;
                end
                n_state = S_A_W2;
            end
            S_A_W2: begin
                link_req.wr    = 1'b1;
                link_req.addr  = lba_pkg::IDX_W'(r_gid);
                link_req.wdata = lba_pkg::NONE_ID;
                size_we        = 1'b1;
                size_addr      = lba_pkg::IDX_W'(r_gid);
                if (r_first >= lba_pkg::NONE_ID) begin
                    n_first = r_gid;
                end
                n_last      = r_gid;
                n_free_head = r_tmp;
                if (r_in_use < lba_pkg::NONE_ID) begin
                    n_in_use = r_in_use + lba_pkg::ID_W'(1);
                end
                n_state = S_DONE;
            end
            S_R_CHK: begin
                if (!bid_ok) begin
                    n_ret   = S_DONE;
                    n_state = r_word.end_of_batch ? S_C_RD : S_DONE;
                end else if (r_run_open) begin
                    link_req.rd   = 1'b1;
                    link_req.addr = lba_pkg::IDX_W'(r_run_end);
                    n_state       = S_R_CMP;
                end else begin
                    n_state = S_R_START;
                end
            end
            S_R_CMP: begin
                if (link_rd == bid) begin
                    n_run_end = bid;
                    if (r_run_len < lba_pkg::NONE_ID) begin
                        n_run_len = r_run_len + lba_pkg::ID_W'(1);
                    end
                    n_ret   = S_DONE;
                    n_state = r_word.end_of_batch ? S_C_RD : S_DONE;
                end else begin
                    n_ret   = S_R_START;
                    n_state = S_C_W1;
                end
            end
            S_R_START: begin
                n_run_open  = 1'b1;
                n_run_start = bid;
                n_run_prev  = pid_ok ? lba_pkg::ID_W'(r_word.prev_id) : lba_pkg::NONE_ID;
                n_run_end   = bid;
                n_run_len   = lba_pkg::ID_W'(1);
                n_ret       = S_DONE;
                n_state     = r_word.end_of_batch ? S_C_RD : S_DONE;
            end
            S_I_RD: begin
                if (bid_ok) begin
                    link_req.rd   = 1'b1;
                    link_req.addr = lba_pkg::IDX_W'(r_word.bkt_sel);
                    size_re       = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.status     = r_status;
                    n_out.granted_id = 7'(r_gid);
                    if (r_word.mode == lba_pkg::MODE_INSPECT && bid_ok) begin
                        n_out.link_out = 7'(link_rd);
                        n_out.size_out = 16'(size_rd);
                    end else begin
                        n_out.link_out = 7'(lba_pkg::NONE_ID);
                        n_out.size_out = '0;
                    end
                    n_out.first_out     = 7'(r_first);
                    n_out.last_out      = 7'(r_last);
                    n_out.free_head_out = 7'(r_free_head);
                    n_out.in_use_out    = 7'(r_in_use);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_DONE;
            r_out_valid <= 1'b0;
            r_free_head <= '0;
            r_first     <= lba_pkg::NONE_ID;
            r_last      <= lba_pkg::NONE_ID;
            r_in_use    <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_run_prev  <= lba_pkg::NONE_ID;
            r_run_end   <= '0;
            r_run_len   <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            r_free_head <= n_free_head;
            r_first     <= n_first;
            r_last      <= n_last;
            r_in_use    <= n_in_use;
            r_run_open  <= n_run_open;
            r_run_start <= n_run_start;
            r_run_prev  <= n_run_prev;
            r_run_end   <= n_run_end;
            r_run_len   <= n_run_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_out    <= n_out;
        r_status <= n_status;
        r_gid    <= n_gid;
        r_tmp    <= n_tmp;
    end

endmodule

`default_nettype wire

### verif/tb_linked_bucket_allocator.sv
// Self-checking testbench for linked_bucket_allocator: grants, batched releases, reads.
// Holds its own model of both lists and checks every result word in order.
// Depends on lba_pkg and the linked_bucket_allocator RTL.
`timescale 1ns / 1ps

module tb_linked_bucket_allocator;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         DIRECTED_WORDS = 21;
    localparam int         RANDOM_WORDS   = 1750;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         STALL_RUN_MAX  = 20;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_style;

    class bucket_list_scoreboard;
        lba_pkg::t_id       link_tbl [lba_pkg::NUM_BUCKETS];
        lba_pkg::t_size     size_tbl [lba_pkg::NUM_BUCKETS];
        bit                 size_written [lba_pkg::NUM_BUCKETS];
        lba_pkg::t_id       free_top;
        lba_pkg::t_id       active_first;
        lba_pkg::t_id       active_last;
        lba_pkg::t_id       active_count;
        bit                 run_pending;
        lba_pkg::t_id       run_head;
        lba_pkg::t_id       run_head_prev;
        lba_pkg::t_id       run_tail;
        lba_pkg::t_id       run_len;
        lba_pkg::t_out_word expected_words [$];
        int                 mismatches;
        int                 results_seen;
        int                 grants;
        int                 refusals;
        int                 release_items;
        int                 runs_closed;
        int                 reads;

        function new();
            for (int i = 0; i < lba_pkg::NUM_BUCKETS; i++) begin
                link_tbl[i]     = lba_pkg::t_id'(i + 1);
                size_tbl[i]     = '0;
                size_written[i] = 1'b0;
            end
            free_top      = '0;
            active_first  = lba_pkg::NONE_ID;
            active_last   = lba_pkg::NONE_ID;
            active_count  = '0;
            run_pending   = 1'b0;
            run_head      = '0;
            run_head_prev = lba_pkg::NONE_ID;
            run_tail      = '0;
            run_len       = '0;
        endfunction

        function bit is_id(lba_pkg::t_id v);
            return v < lba_pkg::NUM_BUCKETS;
        endfunction

        // Cut the open run out of the active list and push it onto the free stack.
        function void close_run();
            lba_pkg::t_id prv;
            lba_pkg::t_id after;
            if (!run_pending)
                return;
            run_pending = 1'b0;
            prv   = run_head_prev;
            after = link_tbl[run_tail];
            if (is_id(prv) && is_id(after)) begin
                link_tbl[prv] = after;
            end else if (is_id(after)) begin
                active_first = after;
            end else if (is_id(prv)) begin
                link_tbl[prv] = lba_pkg::NONE_ID;
                active_last   = prv;
            end else begin
                active_first = lba_pkg::NONE_ID;
                active_last  = lba_pkg::NONE_ID;
            end
            link_tbl[run_tail] = is_id(free_top) ? free_top : lba_pkg::NONE_ID;
            free_top     = run_head;
            active_count = (active_count > run_len) ? active_count - run_len : '0;
            run_len      = '0;
            runs_closed++;
        endfunction

        function void note_input(lba_pkg::t_in_word w);
            lba_pkg::t_out_word r;
            lba_pkg::t_id       bid;
            lba_pkg::t_id       id;
            r            = '0;
            r.granted_id = lba_pkg::NONE_ID;
            r.link_out   = lba_pkg::NONE_ID;
            bid          = lba_pkg::t_id'(w.bkt_sel);
            if (w.mode != lba_pkg::MODE_RELEASE)
                close_run();
            case (w.mode)
                lba_pkg::MODE_ALLOC: begin
                    if (is_id(free_top)) begin
                        id       = free_top;
                        free_top = link_tbl[id];
                        if (active_count < lba_pkg::NUM_BUCKETS)
                            active_count++;
                        if (!is_id(active_first))
                            active_first = id;
                        if (is_id(active_last))
                            link_tbl[active_last] = id;
                        active_last      = id;
                        link_tbl[id]     = lba_pkg::NONE_ID;
                        size_tbl[id]     = w.alloc_size;
                        size_written[id] = 1'b1;
                        r.granted_id     = id;
                        grants++;
                    end else begin
                        r.status = 1'b1;
                        refusals++;
                    end
                end
                lba_pkg::MODE_RELEASE: begin
                    release_items++;
                    if (run_pending && link_tbl[run_tail] == bid) begin
                        run_tail = bid;
                        if (run_len < lba_pkg::NUM_BUCKETS)
                            run_len++;
                    end else begin
                        close_run();
                        run_pending   = 1'b1;
                        run_head      = bid;
                        run_head_prev = is_id(w.prev_id) ? w.prev_id : lba_pkg::NONE_ID;
                        run_tail      = bid;
                        run_len       = lba_pkg::t_id'(1);
                    end
                    if (w.end_of_batch)
                        close_run();
                end
                lba_pkg::MODE_INSPECT: begin
                    r.link_out = is_id(link_tbl[bid]) ? link_tbl[bid] : lba_pkg::NONE_ID;
                    r.size_out = size_tbl[bid];
                    reads++;
                end
                default: ;
            endcase
            r.first_out     = is_id(active_first) ? active_first : lba_pkg::NONE_ID;
            r.last_out      = is_id(active_last) ? active_last : lba_pkg::NONE_ID;
            r.free_head_out = is_id(free_top) ? free_top : lba_pkg::NONE_ID;
            r.in_use_out    = active_count;
            expected_words.push_back(r);
        endfunction

        function void list_active(output lba_pkg::t_id ids [$]);
            lba_pkg::t_id cur;
            ids = {};
            cur = active_first;
            while (is_id(cur) && ids.size() < lba_pkg::NUM_BUCKETS) begin
                ids.push_back(cur);
                cur = link_tbl[cur];
            end
        endfunction

        function void list_written(output lba_pkg::t_id ids [$]);
            ids = {};
            for (int i = 0; i < lba_pkg::NUM_BUCKETS; i++)
                if (size_written[i])
                    ids.push_back(lba_pkg::t_id'(i));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] %s", $time, msg);
        endtask

        task cmp_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                          results_seen, name, got, want));
        endtask

        task check_result(lba_pkg::t_out_word got);
            lba_pkg::t_out_word want;
            results_seen++;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
                return;
            end
            want = expected_words.pop_front();
            cmp_field("status", 16'(got.status), 16'(want.status));
            cmp_field("granted_id", 16'(got.granted_id), 16'(want.granted_id));
            cmp_field("link_out", 16'(got.link_out), 16'(want.link_out));
            cmp_field("size_out", got.size_out, want.size_out);
            cmp_field("first_out", 16'(got.first_out), 16'(want.first_out));
            cmp_field("last_out", 16'(got.last_out), 16'(want.last_out));
            cmp_field("free_head_out", 16'(got.free_head_out), 16'(want.free_head_out));
            cmp_field("in_use_out", 16'(got.in_use_out), 16'(want.in_use_out));
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    lba_pkg::t_in_word  i_word  = '0;
    logic               o_stall;
    logic               o_valid;
    lba_pkg::t_out_word o_word;

    bucket_list_scoreboard sb = new();

    int           words_sent   = 0;
    int           burst_left   = 1;
    int           quiet_cycles = 0;
    int           cyc_count    = 0;
    int           stall_run    = 0;
    t_stall_style stall_style  = STALL_NONE;

    linked_bucket_allocator uut (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_stall,
        .i_word,
        .o_valid,
        .i_stall,
        .o_word
    );

    always #6 i_clk = ~i_clk;

    function automatic lba_pkg::t_in_word rand_word(logic [1:0] m);
        lba_pkg::t_in_word w;
        w.mode         = m;
        w.alloc_size   = 16'($urandom);
        w.bkt_sel      = 6'($urandom);
        w.prev_id      = 7'($urandom);
        w.end_of_batch = 1'($urandom);
        return w;
    endfunction

    // No predecessor: mostly the canonical code, sometimes any larger value.
    function automatic lba_pkg::t_id none_code();
        return ($urandom_range(0, 3) == 0) ? lba_pkg::t_id'($urandom_range(65, 127))
                                           : lba_pkg::NONE_ID;
    endfunction

    task automatic send_word(input lba_pkg::t_in_word w);
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_input(w);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic send_inspect();
        lba_pkg::t_id      ids [$];
        lba_pkg::t_in_word w;
        sb.list_written(ids);
        if (ids.size() == 0) begin
            w = rand_word(lba_pkg::MODE_ALLOC);
        end else begin
            w = rand_word(lba_pkg::MODE_INSPECT);
            w.bkt_sel = ids[$urandom_range(0, ids.size() - 1)][5:0];
        end
        send_word(w);
    endtask

    // Release disjoint stretches of the active list with correct predecessors.
    task automatic release_batch(input int max_segs, input bit drop_eob);
        lba_pkg::t_id      lst [$];
        int                seg_at [$];
        int                seg_len [$];
        int                pos;
        int                len;
        int                n;
        int                idx;
        bit                backwards;
        lba_pkg::t_in_word w;
        sb.list_active(lst);
        n = lst.size();
        if (n == 0) begin
            send_word(rand_word(lba_pkg::MODE_ALLOC));
            return;
        end
        pos = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, n - 1);
        while (pos < n && seg_at.size() < max_segs) begin
            len = $urandom_range(1, (n - pos < 6) ? n - pos : 6);
            seg_at.push_back(pos);
            seg_len.push_back(len);
            pos += len + $urandom_range(1, 3);
        end
        backwards = ($urandom_range(0, 3) == 0);
        for (int s = 0; s < seg_at.size(); s++) begin
            idx = backwards ? seg_at.size() - 1 - s : s;
            for (int k = 0; k < seg_len[idx]; k++) begin
                w = rand_word(lba_pkg::MODE_RELEASE);
                w.bkt_sel = lst[seg_at[idx] + k][5:0];
                if (k == 0)
                    w.prev_id = (seg_at[idx] == 0) ? none_code() : lst[seg_at[idx] - 1];
                w.end_of_batch = !drop_eob && s == seg_at.size() - 1
                                 && k == seg_len[idx] - 1;
                send_word(w);
            end
        end
        if (drop_eob)
            send_word(rand_word($urandom_range(0, 1) ? lba_pkg::MODE_ALLOC : MODE_UNUSED));
    endtask

    initial begin : stimulus
        lba_pkg::t_id      lst [$];
        lba_pkg::t_in_word w;
        int                roll;
        int                alloc_pct;
        bit                filling;
        bit                noisy;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 8; i++) begin
            w = rand_word(lba_pkg::MODE_ALLOC);
            if (i == 0)
                w.alloc_size = '0;
            else if (i == 1)
                w.alloc_size = '1;
            send_word(w);
        end
        for (int i = 0; i < 2; i++) begin
            w = rand_word(lba_pkg::MODE_INSPECT);
            w.bkt_sel = 6'(i);
            send_word(w);
        end
        // tail release: last moves back to the predecessor
        sb.list_active(lst);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[lst.size() - 1][5:0];
        w.prev_id      = lst[lst.size() - 2];
        w.end_of_batch = 1'b1;
        send_word(w);
        // head release, no predecessor
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[0][5:0];
        w.prev_id      = 7'd127;
        w.end_of_batch = 1'b1;
        send_word(w);
        // two linked buckets form one run, left open and closed by a read
        sb.list_active(lst);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[0][5:0];
        w.prev_id      = lba_pkg::NONE_ID;
        w.end_of_batch = 1'b0;
        send_word(w);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[1][5:0];
        w.end_of_batch = 1'b0;
        send_word(w);
        send_inspect();
        // open run closed by the undefined mode
        sb.list_active(lst);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[1][5:0];
        w.prev_id      = lst[0];
        w.end_of_batch = 1'b0;
        send_word(w);
        send_word(rand_word(MODE_UNUSED));
        // one batch, two separate runs
        sb.list_active(lst);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[0][5:0];
        w.prev_id      = none_code();
        w.end_of_batch = 1'b0;
        send_word(w);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[2][5:0];
        w.prev_id      = lst[1];
        w.end_of_batch = 1'b1;
        send_word(w);
        // only bucket left: list becomes empty
        sb.list_active(lst);
        w = rand_word(lba_pkg::MODE_RELEASE);
        w.bkt_sel      = lst[0][5:0];
        w.prev_id      = none_code();
        w.end_of_batch = 1'b1;
        send_word(w);
        send_word(rand_word(MODE_UNUSED));

        // alternating fill and drain phases; misuse only near the end
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            filling   = ((words_sent / 150) % 2) == 0;
            noisy     = words_sent > DIRECTED_WORDS + RANDOM_WORDS * 85 / 100;
            alloc_pct = filling ? 80 : 25;
            roll      = $urandom_range(0, 99);
            if (noisy && roll < 15) begin
                w = rand_word(lba_pkg::MODE_RELEASE);
                w.end_of_batch = ($urandom_range(0, 2) == 0);
                send_word(w);
            end else if (roll < alloc_pct) begin
                send_word(rand_word(lba_pkg::MODE_ALLOC));
            end else if (roll < alloc_pct + 8) begin
                send_inspect();
            end else if (roll < alloc_pct + 10) begin
                send_word(rand_word(MODE_UNUSED));
            end else begin
                release_batch(filling ? 1 : 4, $urandom_range(0, 6) == 0);
            end
        end

        i_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d words driven: %0d grants, %0d refused, %0d reads",
                 words_sent, sb.grants, sb.refusals, sb.reads);
        $display("%0d release words closing %0d runs, %0d results checked",
                 sb.release_items, sb.runs_closed, sb.results_seen);
        if (sb.mismatches == 0)
            $display("linked_bucket_allocator: match");
        else
            $display("linked_bucket_allocator: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_result(o_word);
    end

    // receiver stall: randomly redrawn style, runs capped
    always @(posedge i_clk) begin
        logic hold;
        cyc_count++;
        if (cyc_count % 200 == 0)
            stall_style = t_stall_style'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:  hold = 1'b0;
            STALL_LIGHT: hold = ($urandom_range(0, 4) == 0);
            STALL_HEAVY: hold = ($urandom_range(0, 3) != 0);
            default:     hold = (cyc_count % 7) < 3;
        endcase
        if (stall_run >= STALL_RUN_MAX)
            hold = 1'b0;
        stall_run = hold ? stall_run + 1 : 0;
        i_stall <= hold;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("linked_bucket_allocator: mismatch");
        $finish;
    end

endmodule
